/* rtl/core/sorted_key_table_top_macros.svh */
// Assertion macros for the sorted key table.
// Used by sorted_key_table_top; expects clk_i and rst_ni in scope.
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sktab_pkg.sv */
// Package for the sorted key table: sizes, codes, link and hit structs.
// Used by sktab_cell, sktab_group and sorted_key_table_top; no dependencies.
package sktab_pkg;

  // Table size and field widths.
  localparam int TABLE_CAPACITY = 1024;
  localparam int KEY_BITS       = 32;
  localparam int KEY_IN_W       = 32;
  localparam int HANDLE_W       = 16;
  localparam int ACTION_W       = 2;
  localparam int STATUS_W       = 2;
  localparam int POS_W          = 10;

  // Cells are grouped so that each reduction step spans at most 32 leaves.
  localparam int GROUP_SIZE = (TABLE_CAPACITY < 32) ? TABLE_CAPACITY : 32;
  localparam int NUM_GROUPS = (TABLE_CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NUM_CELLS  = NUM_GROUPS * GROUP_SIZE;
  localparam int CELL_IDX_W = $clog2(NUM_CELLS);
  localparam int GRP_IDX_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CNT_W      = $clog2(TABLE_CAPACITY + 1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [HANDLE_W-1:0]   handle_t;
  typedef logic [CELL_IDX_W-1:0] cell_idx_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [GRP_IDX_W-1:0]  grp_idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_IGNORE = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  // What a cell hands to its upper neighbour.
  typedef struct packed {
    key_t    key;
    handle_t handle;
    logic    lt;
  } cell_link_t;

  // Query broadcast to every cell.
  typedef struct packed {
    key_t    key;
    handle_t handle;
    count_t  count;
    logic    shift;
  } query_t;

  // Search result of a cell, a group or the whole table.
  typedef struct packed {
    logic      first;
    logic      found;
    cell_idx_t idx;
    handle_t   handle;
  } hit_t;

  // Reduce an incoming key to the stored key width.
  function automatic key_t key_norm(input logic [KEY_IN_W-1:0] k);
    logic [63:0] wide;
    wide = {{(64 - KEY_IN_W){1'b0}}, k};
    return wide[KEY_BITS-1:0];
  endfunction

endpackage

/* rtl/core/sorted_key_table_top.sv */
// Channel   | Direction | Content
// s_axis    | in        | tuser: action; tdata: key, entry_handle
// m_axis    | out       | tuser: status; tdata: position, found_handle
//
// Each item passes five steps: acceptance, the compare in every cell, the
// group reduction, the table-wide reduction and the commit step, where an
// insert shifts the whole cell chain at once. The result is registered in
// the commit step; the input is ready again when that result is offered.
// A result held back by m_axis_tready_i keeps the commit step waiting.
// After reset the table is empty; entry storage needs no clearing pass.
//
// Top level of the sorted key table. Depends on sktab_pkg, sktab_group,
// sktab_cell and sorted_key_table_top_macros.svh.
`include "sorted_key_table_top_macros.svh"

module sorted_key_table_top import sktab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // key [31:0], entry_handle [47:32]
  input  logic [1:0]  s_axis_tuser_i,  // action [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // position [9:0], found_handle [25:10], zero
  output logic [1:0]  m_axis_tuser_o   // status [1:0]
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_GRP  = 5'b00100,
    S_TOP  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e   state_q, state_d;
  action_e  action_q;
  key_t     key_q;
  handle_t  handle_q;
  count_t   count_q, count_d;
  query_t   query;
  hit_t     top_q, top_d;
  hit_t     grp_hits  [NUM_GROUPS];
  cell_link_t grp_links [NUM_GROUPS+1];
  logic [NUM_GROUPS-1:0] grp_first;

  logic     out_valid_q;
  status_e  out_status_q, status;
  logic [POS_W-1:0]  out_pos_q, pos;
  handle_t  out_handle_q, fhandle;
  logic [31:0] idx_wide;
  logic     full;
  logic     done_go;
  logic     shift;
  logic     accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // Item registers, loaded on an input transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_e'(s_axis_tuser_i);
      key_q    <= key_norm(s_axis_tdata_i[31:0]);
      handle_q <= s_axis_tdata_i[47:32];
    end
  end

  // Commit step may proceed once the output register is free.
  assign done_go = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);
  assign full    = (count_q == CNT_W'(TABLE_CAPACITY));

  // Result selection from the table-wide hit.
  assign idx_wide = 32'(top_q.idx);
  always_comb begin
    status  = ST_OK;
    pos     = '0;
    fhandle = '0;
    shift   = 1'b0;
    case (action_q)
      ACT_LOOKUP: begin
        if (top_q.found) begin
          pos     = idx_wide[POS_W-1:0];
          fhandle = top_q.handle;
        end else begin
          status = ST_MISS;
        end
      end
      ACT_INSERT: begin
        if (top_q.found) begin
          status = ST_DUP;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          pos   = idx_wide[POS_W-1:0];
          shift = done_go;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Fill count.
  always_comb begin
    count_d = count_q;
    if (shift) begin
      count_d = count_q + 1'b1;
    end else if (done_go && (action_q == ACT_CLEAR)) begin
      count_d = '0;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_GRP;
      end
      S_GRP: begin
        state_d = S_TOP;
      end
      S_TOP: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (done_go) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (done_go) begin
      out_status_q <= status;
      out_pos_q    <= pos;
      out_handle_q <= fhandle;
    end
  end

  // Query broadcast to the cell chain.
  assign query.key    = key_q;
  assign query.handle = handle_q;
  assign query.count  = count_q;
  assign query.shift  = shift;

  // The cell below the first one reads as smaller than any key.
  assign grp_links[0].key    = '0;
  assign grp_links[0].handle = '0;
  assign grp_links[0].lt     = 1'b1;

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    sktab_group u_group (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .grp_i   (GRP_IDX_W'(g)),
      .query_i (query),
      .prev_i  (grp_links[g]),
      .link_o  (grp_links[g+1]),
      .hit_o   (grp_hits[g])
    );
    assign grp_first[g] = grp_hits[g].first;
  end

  // Table-wide reduction over the group results.
  always_comb begin
    top_d = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      top_d.first  = top_d.first | grp_hits[g].first;
      top_d.found  = top_d.found | grp_hits[g].found;
      top_d.idx    = top_d.idx | grp_hits[g].idx;
      top_d.handle = top_d.handle | grp_hits[g].handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else begin
      top_q <= top_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {6'b0, out_handle_q, out_pos_q};

  // Checks on the table logic.
  `SKT_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_q) <= TABLE_CAPACITY, "fill count over capacity")
  `SKT_ASSERT_IMP(a_one_insert_point, 1'b1, $onehot0(grp_first), "several insertion points")
  `SKT_ASSERT_NXT(a_insert_grows, shift, count_q == $past(count_q) + 1'b1, "insert lost count")

endmodule

/* rtl/core/sktab_cell.sv */
// One table cell: holds a key and handle, compares the key with the query and
// takes its lower neighbour's entry on an insert. Depends on sktab_pkg.
module sktab_cell import sktab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_idx_t  idx_i,
  input  query_t     query_i,
  input  cell_link_t prev_i,
  output cell_link_t link_o,
  output hit_t       hit_o
);

  key_t    key_q, key_d;
  handle_t handle_q, handle_d;
  logic    lt_q, lt_d;
  logic    eq_q, eq_d;
  logic    valid;
  logic    first;

  // The cell holds a live entry when its index lies below the fill count.
  assign valid = 32'(idx_i) < 32'(query_i.count);
  assign lt_d  = valid && (key_q < query_i.key);
  assign eq_d  = valid && (key_q == query_i.key);

  // Insertion point: the lowest cell whose key is not below the query.
  assign first = !lt_q && prev_i.lt;

  // On an insert, lower cells keep, the insertion cell loads the new entry
  // and every cell above takes its neighbour's entry.
  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (query_i.shift && !lt_q) begin
      if (first) begin
        key_d    = query_i.key;
        handle_d = query_i.handle;
      end else begin
        key_d    = prev_i.key;
        handle_d = prev_i.handle;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  // Compare flags, refreshed every cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  assign link_o.key    = key_q;
  assign link_o.handle = handle_q;
  assign link_o.lt     = lt_q;

  assign hit_o.first  = first;
  assign hit_o.found  = eq_q;
  assign hit_o.idx    = idx_i;
  assign hit_o.handle = handle_q;

endmodule

/* rtl/core/sktab_group.sv */
// A group of chained table cells with a registered reduction of their hits.
// Depends on sktab_pkg and sktab_cell.
module sktab_group import sktab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  grp_idx_t   grp_i,
  input  query_t     query_i,
  input  cell_link_t prev_i,
  output cell_link_t link_o,
  output hit_t       hit_o
);

  cell_link_t links [GROUP_SIZE+1];
  hit_t       hits  [GROUP_SIZE];
  hit_t       hit_q, hit_d;

  assign links[0] = prev_i;

  // Cell chain; each cell sees its lower neighbour's link.
  for (genvar l = 0; l < GROUP_SIZE; l++) begin : g_cell
    sktab_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (CELL_IDX_W'(32'(grp_i) * GROUP_SIZE + l)),
      .query_i (query_i),
      .prev_i  (links[l]),
      .link_o  (links[l+1]),
      .hit_o   (hits[l])
    );
  end

  assign link_o = links[GROUP_SIZE];

  // At most one cell in the table is the insertion point, so an OR suffices.
  always_comb begin
    hit_d = '0;
    for (int l = 0; l < GROUP_SIZE; l++) begin
      hit_d.first  = hit_d.first | hits[l].first;
      hit_d.found  = hit_d.found | (hits[l].first & hits[l].found);
      hit_d.idx    = hit_d.idx | (hits[l].first ? hits[l].idx : '0);
      hit_d.handle = hit_d.handle |
                     ((hits[l].first && hits[l].found) ? hits[l].handle : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

/* dv/sorted_key_table_top_tb.sv */
// Self-checking testbench for sorted_key_table_top: lookups, inserts and clears
// are predicted by a scoreboard class that keeps its own sorted table.
// Depends on sktab_pkg and sorted_key_table_top.
module sorted_key_table_top_tb;
  import sktab_pkg::*;

  localparam int RANDOM_ITEMS   = 40;
  localparam int CALM_ITEMS     = 40;
  localparam int PRESSURE_AFTER = 60;
  localparam int PRESSURE_HOLD  = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  // One result as it should leave the m_axis side.
  typedef struct {
    status_e          status;
    logic [POS_W-1:0] position;
    handle_t          found_handle;
  } reply_t;

  // Keeps a sorted copy of the table and the replies still owed by the block.
  class table_checker;
    key_t    table_keys[TABLE_CAPACITY];
    handle_t table_handles[TABLE_CAPACITY];
    int      entry_total;
    reply_t  owed_replies[$];
    int      errors;

    function new();
      entry_total = 0;
      errors      = 0;
    endfunction

    function int entries();
      return entry_total;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    function key_t stored_key(int idx);
      return table_keys[idx];
    endfunction

    // Binary search: returns the match index, or the insertion index on a miss.
    function bit find_slot(input key_t k, output int slot);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = entry_total;
      while (hi > lo) begin
        mid = lo + ((hi - lo) >> 1);
        if (table_keys[mid] < k) begin
          lo = mid + 1;
        end else if (table_keys[mid] > k) begin
          hi = mid;
        end else begin
          slot = mid;
          return 1'b1;
        end
      end
      slot = lo;
      return 1'b0;
    endfunction

    // Applies one action to the local table and works out its reply.
    function reply_t predict_reply(action_e act, key_t k, handle_t h);
      reply_t r;
      int     slot;
      bit     hit;
      r.status       = ST_OK;
      r.position     = '0;
      r.found_handle = '0;
      case (act)
        ACT_LOOKUP: begin
          hit = find_slot(k, slot);
          if (hit) begin
            r.position     = POS_W'(slot);
            r.found_handle = table_handles[slot];
          end else begin
            r.status = ST_MISS;
          end
        end
        ACT_INSERT: begin
          hit = find_slot(k, slot);
          if (hit) begin
            r.status = ST_DUP;
          end else if (entry_total >= TABLE_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            // Later entries move up by one to open the slot.
            for (int i = entry_total; i > slot; i--) begin
              table_keys[i]    = table_keys[i-1];
              table_handles[i] = table_handles[i-1];
            end
            table_keys[slot]    = k;
            table_handles[slot] = h;
            entry_total++;
            r.position = POS_W'(slot);
          end
        end
        ACT_CLEAR: begin
          entry_total = 0;
        end
        default: begin
          // The unused action leaves the table alone.
        end
      endcase
      return r;
    endfunction

    function void note_request(action_e act, logic [KEY_IN_W-1:0] k, handle_t h);
      owed_replies.push_back(predict_reply(act, key_t'(k), h));
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                              handle_t found_handle);
      reply_t exp_r;
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected result, status %0d position %0d handle %0h",
                 $time, status, position, found_handle);
        errors++;
        return;
      end
      exp_r = owed_replies.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, exp_r.status, status);
        errors++;
      end
      if (position !== exp_r.position) begin
        $display("%0t: position expected %0d, actual %0d", $time, exp_r.position, position);
        errors++;
      end
      if (found_handle !== exp_r.found_handle) begin
        $display("%0t: found_handle expected %0h, actual %0h", $time, exp_r.found_handle,
                 found_handle);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = ACT_LOOKUP;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  table_checker sb = new();
  bit           calm_tail = 1'b0;
  int           replies_seen = 0;
  int           quiet_cycles = 0;
  int           quiet_probe_slot;

  sorted_key_table_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly full-range keys, with some close to either end of the range.
  function automatic logic [31:0] random_key();
    case ($urandom_range(0, 4))
      0:       return 32'($urandom_range(0, 15));
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Offers one item, optionally after an idle burst, and waits for its transfer.
  task automatic offer_item(action_e act, logic [31:0] k, handle_t h);
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {h, k};
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(act, k, h);
  endtask

  // Fills the table to capacity, then probes the full-table cases.
  task automatic fill_table();
    logic [31:0] k;
    for (int i = 0; i < TABLE_CAPACITY; i++) begin
      offer_item(ACT_INSERT, {22'($urandom()), 10'(i)}, 16'($urandom()));
    end
    offer_item(ACT_INSERT, sb.stored_key($urandom_range(0, TABLE_CAPACITY - 1)), 16'hBEEF);
    do k = random_key(); while (sb.find_slot(key_t'(k), quiet_probe_slot));
    offer_item(ACT_INSERT, k, 16'h1234);
    offer_item(ACT_LOOKUP, k, 16'h0);
    offer_item(ACT_LOOKUP, sb.stored_key(0), 16'h0);
    offer_item(ACT_LOOKUP, sb.stored_key(TABLE_CAPACITY - 1), 16'hFFFF);
    offer_item(ACT_CLEAR, k, 16'h0);
  endtask

  // Stimulus: directed items, a full table, then a random mix.
  initial begin
    int          counted;
    int          pick;
    handle_t     h;
    counted = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_item(ACT_LOOKUP, 32'h0000_0000, 16'h0000);
    offer_item(ACT_IGNORE, 32'hFFFF_FFFF, 16'hFFFF);
    offer_item(ACT_INSERT, 32'h0000_0000, 16'h0000);
    offer_item(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    offer_item(ACT_INSERT, 32'h8000_0000, 16'h5555);
    offer_item(ACT_INSERT, 32'h0000_0000, 16'h7777);
    offer_item(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
    offer_item(ACT_LOOKUP, 32'h8000_0000, 16'hFFFF);
    offer_item(ACT_LOOKUP, 32'h7FFF_FFFF, 16'h0000);
    offer_item(ACT_INSERT, 32'h7FFF_FFFF, 16'hAAAA);
    offer_item(ACT_IGNORE, 32'h0000_0000, 16'h0000);
    offer_item(ACT_LOOKUP, 32'h7FFF_FFFF, 16'h0000);
    offer_item(ACT_LOOKUP, 32'h0000_0000, 16'h0000);
    offer_item(ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
    offer_item(ACT_LOOKUP, 32'h0000_0000, 16'h0000);
    offer_item(ACT_INSERT, 32'h0000_0005, 16'h8001);
    offer_item(ACT_LOOKUP, 32'h0000_0005, 16'h0000);
    offer_item(ACT_CLEAR, 32'h0000_0000, 16'h0000);

    fill_table();

    // Random mix: mostly fresh inserts and lookups of stored keys.
    while (counted < RANDOM_ITEMS) begin
      calm_tail = (counted >= RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 99);
      h    = 16'($urandom());
      if (pick < 45) begin
        offer_item(ACT_INSERT, random_key(), h);
      end else if (pick < 60 && sb.entries() > 0) begin
        offer_item(ACT_INSERT, sb.stored_key($urandom_range(0, sb.entries() - 1)), h);
      end else if (pick < 80 && sb.entries() > 0) begin
        offer_item(ACT_LOOKUP, sb.stored_key($urandom_range(0, sb.entries() - 1)), h);
      end else if (pick < 97) begin
        offer_item(ACT_LOOKUP, random_key(), h);
      end else if (pick < 98) begin
        offer_item(ACT_CLEAR, random_key(), h);
      end else begin
        offer_item(ACT_IGNORE, random_key(), h);
        counted--;
      end
      counted++;
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: checks each transfer and stalls in random bursts, once for long.
  initial begin
    int  hold_left;
    bit  pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_reply(m_axis_tuser_o, m_axis_tdata_o[POS_W-1:0],
                       m_axis_tdata_o[POS_W+HANDLE_W-1:POS_W]);
        replies_seen++;
      end
      if (!pressure_done && replies_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        hold_left       = $urandom_range(1, 17) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when neither side has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
